FILE: rtl/mm4_pkg.sv
// Shared types and constants for the 4x4 fixed-point matrix multiplier.
package mm4_pkg;

    localparam int ELEM_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int DIM        = 4;
    localparam int PORT_ELEM  = 32;
    localparam int TDATA_W    = 136;
    localparam int PROD_W     = 2 * ELEM_WIDTH;
    localparam int PAIR_W     = PROD_W + 1;
    localparam int SUM_W      = PROD_W + 2;
    localparam int SHIFT_W    = SUM_W - FRAC_BITS;

    localparam logic [1:0] ACT_LOAD_LEFT  = 2'd0;
    localparam logic [1:0] ACT_LOAD_RIGHT = 2'd1;
    localparam logic [1:0] ACT_MULTIPLY   = 2'd2;

    typedef logic signed [ELEM_WIDTH-1:0] elem_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [PAIR_W-1:0]     pair_t;
    typedef logic signed [SUM_W-1:0]      sum_t;
    typedef logic signed [SHIFT_W-1:0]    shift_t;
    typedef logic [1:0]                   col_t;

    typedef struct packed {
        logic en_left;
        logic en_right;
        col_t column;
    } store_wr_t;

    typedef struct packed {
        logic valid;
        col_t column;
        logic last;
    } lane_ctl_t;

endpackage

FILE: rtl/mm4_store.sv
// Left and right operand stores, column load, full left read and per-column right read.
module mm4_store
    import mm4_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  store_wr_t wr,
    input  elem_t     wr_elem   [DIM],
    input  col_t      rd_column,
    output elem_t     left_rows [DIM][DIM],
    output elem_t     right_col [DIM]
);

    elem_t left_reg  [DIM*DIM];
    elem_t right_reg [DIM*DIM];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIM*DIM; i++) begin
                left_reg[i]  <= '0;
                right_reg[i] <= '0;
            end
        end else begin
            for (int r = 0; r < DIM; r++) begin
                if (wr.en_left) begin
                    left_reg[{wr.column, 2'(r)}] <= wr_elem[r];
                end
                if (wr.en_right) begin
                    right_reg[{wr.column, 2'(r)}] <= wr_elem[r];
                end
            end
        end
    end

    always_comb begin
        for (int j = 0; j < DIM; j++) begin
            for (int k = 0; k < DIM; k++) begin
                left_rows[j][k] = left_reg[{2'(k), 2'(j)}];
            end
            right_col[j] = right_reg[{rd_column, 2'(j)}];
        end
    end

endmodule

FILE: rtl/mm4_lane.sv
// One dot-product lane: four multipliers, then a registered adder tree.
module mm4_lane
    import mm4_pkg::*;
(
    input  logic  aclk,
    input  logic  adv,
    input  elem_t left_row  [DIM],
    input  elem_t right_col [DIM],
    output sum_t  sum
);

    prod_t prod_reg [DIM];
    pair_t pair_reg [2];
    sum_t  sum_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < DIM; k++) begin
                prod_reg[k] <= left_row[k] * right_col[k];
            end
            pair_reg[0] <= PAIR_W'(prod_reg[0]) + PAIR_W'(prod_reg[1]);
            pair_reg[1] <= PAIR_W'(prod_reg[2]) + PAIR_W'(prod_reg[3]);
            sum_reg     <= SUM_W'(pair_reg[0]) + SUM_W'(pair_reg[1]);
        end
    end

    assign sum = sum_reg;

endmodule

FILE: rtl/mm4_merge.sv
// Merges the four lane sums: scale, saturate and register the result column.
module mm4_merge
    import mm4_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  lane_ctl_t          ctl,
    input  sum_t               lane_sum [DIM],
    output logic               m_tvalid,
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tlast
);

    localparam shift_t SAT_MAX = {{(SHIFT_W-ELEM_WIDTH+1){1'b0}}, {(ELEM_WIDTH-1){1'b1}}};
    localparam shift_t SAT_MIN = {{(SHIFT_W-ELEM_WIDTH+1){1'b1}}, {(ELEM_WIDTH-1){1'b0}}};

    logic               m_tvalid_reg;
    logic [TDATA_W-1:0] m_tdata_reg;
    logic [TDATA_W-1:0] m_tdata_next;
    logic               m_tlast_reg;
    shift_t             scaled [DIM];
    elem_t              sat    [DIM];

    always_comb begin
        m_tdata_next      = '0;
        m_tdata_next[1:0] = ctl.column;
        for (int j = 0; j < DIM; j++) begin
            scaled[j] = shift_t'(lane_sum[j] >>> FRAC_BITS);
            if (scaled[j] > SAT_MAX) begin
                sat[j] = elem_t'(SAT_MAX);
            end else if (scaled[j] < SAT_MIN) begin
                sat[j] = elem_t'(SAT_MIN);
            end else begin
                sat[j] = elem_t'(scaled[j]);
            end
            m_tdata_next[2 + PORT_ELEM*j +: PORT_ELEM] = PORT_ELEM'(sat[j]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= m_tdata_next;
            m_tlast_reg <= ctl.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

FILE: rtl/matrix4x4_multiply_unit.sv
// Top level: 4x4 Q16.16 matrix multiplier with four row lanes.
// A multiply issues one product column per cycle into the lanes while the output is not
// stalled; column 0 passes the lane product, pair and sum registers and the merge output
// register, the rest follow one per cycle while not stalled, and the next item is taken
// as the last column issues. Output stalls freeze the multiplier and adder stages of all lanes.
// aresetn (synchronous, active low) zeroes both operand stores and the pipeline valid flags.
module matrix4x4_multiply_unit
    import mm4_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,  // column[1:0], elem_row0..3 32 bits each, pad
    input  logic [1:0]         s_tuser,  // action[1:0]
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,  // out_column[1:0], prod_row0..3 32 bits each, pad
    output logic               m_tlast
);

    logic      busy_reg, busy_next;
    col_t      cnt_reg, cnt_next;
    lane_ctl_t ctl_reg [3];
    lane_ctl_t ctl_in;
    logic      adv;
    logic      s_acc;
    store_wr_t wr;
    elem_t     wr_elem   [DIM];
    elem_t     left_rows [DIM][DIM];
    elem_t     right_col [DIM];
    sum_t      lane_sum  [DIM];

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = !busy_reg || (adv && cnt_reg == 2'd3);
    assign s_acc    = s_tvalid && s_tready;

    always_comb begin
        wr.en_left  = s_acc && s_tuser == ACT_LOAD_LEFT;
        wr.en_right = s_acc && s_tuser == ACT_LOAD_RIGHT;
        wr.column   = s_tdata[1:0];
        for (int r = 0; r < DIM; r++) begin
            wr_elem[r] = elem_t'(s_tdata[2 + PORT_ELEM*r +: ELEM_WIDTH]);
        end
    end

    always_comb begin
        busy_next     = busy_reg;
        cnt_next      = cnt_reg;
        ctl_in.valid  = busy_reg;
        ctl_in.column = cnt_reg;
        ctl_in.last   = cnt_reg == 2'd3;
        if (busy_reg && adv) begin
            cnt_next = cnt_reg + 2'd1;
            if (cnt_reg == 2'd3) begin
                busy_next = 1'b0;
            end
        end
        if (s_acc && s_tuser == ACT_MULTIPLY) begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            for (int s = 0; s < 3; s++) begin
                ctl_reg[s] <= '0;
            end
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            if (adv) begin
                ctl_reg[0] <= ctl_in;
                ctl_reg[1] <= ctl_reg[0];
                ctl_reg[2] <= ctl_reg[1];
            end
        end
    end

    mm4_store u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr        (wr),
        .wr_elem   (wr_elem),
        .rd_column (cnt_reg),
        .left_rows (left_rows),
        .right_col (right_col)
    );

    for (genvar j = 0; j < DIM; j++) begin : g_lane
        mm4_lane u_lane (
            .aclk      (aclk),
            .adv       (adv),
            .left_row  (left_rows[j]),
            .right_col (right_col),
            .sum       (lane_sum[j])
        );
    end

    mm4_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .ctl      (ctl_reg[2]),
        .lane_sum (lane_sum),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: rtl/mm4_checker.sv
// Port-level assertions for the matrix multiplier, bound to the top level.
module mm4_checker
    import mm4_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic [1:0]         s_tuser,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic               m_tlast
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    a_last_marks_col3: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[1:0] == 2'd3)))
        else $error("last flag does not match column 3");

    a_columns_back_to_back: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && m_tdata[1:0] == $past(m_tdata[1:0]) + 2'd1)
        else $error("product columns not contiguous");

    a_busy_after_multiply: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == ACT_MULTIPLY |=> !s_tready)
        else $error("input accepted during product issue");

endmodule

bind matrix4x4_multiply_unit mm4_checker u_mm4_checker (.*);

FILE: test/matrix4x4_multiply_checker.sv
// Watches both channels, predicts product columns and compares what the block emits.
module matrix4x4_multiply_checker
    import mm4_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,
    input  logic [1:0]         s_tuser,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [TDATA_W-1:0] m_tdata,
    input  logic               m_tlast,
    output int                 mismatches,
    output int                 results_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ACC_W = 2 * ELEM_WIDTH + 2;

    typedef struct {
        logic [1:0]  column;
        logic [31:0] rows [4];
        logic        last;
    } product_column_t;

    logic [31:0]     left_elems  [16];
    logic [31:0]     right_elems [16];
    product_column_t product_columns_q [$];

    initial begin
        mismatches      = 0;
        results_pending = 0;
    end

    // Exact dot product, floor shift by the fraction width, saturate to ELEM_WIDTH.
    function automatic logic [31:0] dot_lane(int row, int col);
        logic signed [ACC_W-1:0]      acc;
        logic signed [ACC_W-1:0]      maxv;
        logic signed [ACC_W-1:0]      minv;
        logic signed [ELEM_WIDTH-1:0] a;
        logic signed [ELEM_WIDTH-1:0] b;
        logic signed [ELEM_WIDTH-1:0] narrow;
        logic signed [31:0]           wide;
        acc = '0;
        for (int k = 0; k < DIM; k++) begin
            a   = left_elems[k * 4 + row][ELEM_WIDTH-1:0];
            b   = right_elems[col * 4 + k][ELEM_WIDTH-1:0];
            acc = acc + a * b;
        end
        acc  = acc >>> FRAC_BITS;
        maxv = 1;
        maxv = (maxv <<< (ELEM_WIDTH - 1)) - 1;
        minv = -maxv - 1;
        if (acc > maxv) acc = maxv;
        if (acc < minv) acc = minv;
        narrow = acc[ELEM_WIDTH-1:0];
        wide   = narrow;
        return wide;
    endfunction

    function automatic product_column_t predict_column(int col);
        product_column_t pc;
        pc.column = col[1:0];
        for (int r = 0; r < DIM; r++) pc.rows[r] = dot_lane(r, col);
        pc.last = (col == DIM - 1);
        return pc;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] %s: got %h, want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        product_column_t want;
        logic [31:0]     got_row;
        if (!aresetn) begin
            for (int i = 0; i < 16; i++) begin
                left_elems[i]  = '0;
                right_elems[i] = '0;
            end
            product_columns_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (product_columns_q.size() == 0) begin
                    report_mismatch("result with none expected", m_tdata[31:0], '0);
                end else begin
                    want = product_columns_q.pop_front();
                    if (m_tdata[1:0] !== want.column)
                        report_mismatch("out_column", 32'(m_tdata[1:0]), 32'(want.column));
                    for (int r = 0; r < DIM; r++) begin
                        got_row = m_tdata[2 + 32 * r +: 32];
                        if (got_row !== want.rows[r])
                            report_mismatch($sformatf("prod_row%0d of column %0d", r,
                                                      want.column), got_row, want.rows[r]);
                    end
                    if (m_tlast !== want.last)
                        report_mismatch("last_column", 32'(m_tlast), 32'(want.last));
                end
            end
            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    ACT_LOAD_LEFT: begin
                        for (int r = 0; r < DIM; r++)
                            left_elems[s_tdata[1:0] * 4 + r] = s_tdata[2 + 32 * r +: 32];
                    end
                    ACT_LOAD_RIGHT: begin
                        for (int r = 0; r < DIM; r++)
                            right_elems[s_tdata[1:0] * 4 + r] = s_tdata[2 + 32 * r +: 32];
                    end
                    ACT_MULTIPLY: begin
                        for (int c = 0; c < DIM; c++)
                            product_columns_q.push_back(predict_column(c));
                    end
                    default: ;
                endcase
            end
        end
        results_pending = product_columns_q.size();
    end

endmodule

FILE: test/tb_matrix4x4_multiply_unit.sv
// Stimulus and verdict for the 4x4 fixed-point matrix multiplier.
module tb_matrix4x4_multiply_unit
    import mm4_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [31:0] Q_ONE     = 32'h0001_0000;
    localparam logic [31:0] E_MAX     = 32'h7fff_ffff;
    localparam logic [31:0] E_MIN     = 32'h8000_0000;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata;
    logic [1:0]         s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tlast;
    int                 mismatches;
    int                 results_pending;
    bit                 steady_phase;

    matrix4x4_multiply_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    matrix4x4_multiply_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .mismatches      (mismatches),
        .results_pending (results_pending)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic int draw_wait();
        if (steady_phase) return 0;
        return $urandom_range(0, 14);
    endfunction

    function automatic logic [31:0] rand_elem();
        logic [31:0] mag;
        case ($urandom_range(0, 9))
            0: return E_MAX;
            1: return E_MIN;
            2: return '0;
            3: return 32'hffff_ffff;
            4, 5, 6: begin
                mag = $urandom_range(0, 32'h0004_0000);
                return $urandom_range(0, 1) ? -mag : mag;
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(logic [1:0] act, logic [1:0] col, logic [3:0][31:0] rows);
        int gap;
        gap = draw_wait();
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= TDATA_W'({rows, col});
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic load_uniform(logic [1:0] act, logic [31:0] v);
        for (int c = 0; c < DIM; c++) send_item(act, c[1:0], {v, v, v, v});
    endtask

    // Result side: random stall before each transaction, none in the steady phase.
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            stall = draw_wait();
            repeat (stall) begin
                @(negedge aclk);
                m_tready <= 1'b0;
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        logic [3:0][31:0] rows;
        int               pick;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = ACT_LOAD_LEFT;
        steady_phase = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Product of the cleared stores.
        send_item(ACT_MULTIPLY, 2'd0, '0);
        // Identity on the left, extremes on the right.
        for (int c = 0; c < DIM; c++) begin
            rows    = '0;
            rows[c] = Q_ONE;
            send_item(ACT_LOAD_LEFT, c[1:0], rows);
        end
        send_item(ACT_LOAD_RIGHT, 2'd0, {32'hffff_ffff, 32'h0000_0001, E_MIN, E_MAX});
        send_item(ACT_LOAD_RIGHT, 2'd1, {E_MAX, E_MIN, 32'hffff_ffff, 32'h0000_0000});
        send_item(ACT_LOAD_RIGHT, 2'd2, {32'h5555_5555, 32'haaaa_aaaa, E_MAX, E_MIN});
        send_item(ACT_LOAD_RIGHT, 2'd3, {32'hfffe_8000, Q_ONE, 32'h0000_8000, E_MAX});
        send_item(ACT_MULTIPLY, 2'd1, {E_MAX, E_MAX, E_MAX, E_MAX});
        // Unused action code must leave the stores alone.
        send_item(ACT_UNUSED, 2'd2, {E_MIN, E_MIN, E_MIN, E_MIN});
        send_item(ACT_MULTIPLY, 2'd3, '0);
        // Full-scale left, mixed right: floor rounding of negative sums.
        load_uniform(ACT_LOAD_LEFT, E_MAX);
        send_item(ACT_MULTIPLY, 2'd2, '0);
        // Negative saturation, then positive saturation in one column.
        load_uniform(ACT_LOAD_RIGHT, E_MIN);
        send_item(ACT_MULTIPLY, 2'd0, '0);
        send_item(ACT_LOAD_RIGHT, 2'd2, {E_MAX, E_MAX, E_MAX, E_MAX});
        send_item(ACT_MULTIPLY, 2'd0, '0);

        for (int n = 0; n < 325; n++) begin
            if ($urandom_range(0, 39) == 0) steady_phase = ~steady_phase;
            for (int r = 0; r < DIM; r++) rows[r] = rand_elem();
            pick = $urandom_range(0, 99);
            if (pick < 3)
                send_item(ACT_UNUSED, 2'($urandom), rows);
            else if (pick < 20)
                send_item(ACT_MULTIPLY, 2'($urandom), rows);
            else if (pick < 60)
                send_item(ACT_LOAD_LEFT, 2'($urandom), rows);
            else
                send_item(ACT_LOAD_RIGHT, 2'($urandom), rows);
        end
        send_item(ACT_MULTIPLY, 2'd0, '0);
        @(negedge aclk);
        s_tvalid <= 1'b0;

        wait (results_pending == 0);
        repeat (40) @(posedge aclk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
